/* rtl/cooperative_task_scheduler_macros.svh */
// Assertion macros for the cooperative task scheduler.
// Expects clk and rst_n in the scope of each use.
`ifndef COOPERATIVE_TASK_SCHEDULER_MACROS_SVH
`define COOPERATIVE_TASK_SCHEDULER_MACROS_SVH

// Same-cycle implication.
`define CTS_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cts: same-cycle check failed");

// Next-cycle implication.
`define CTS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cts: next-cycle check failed");

`endif

/* rtl/cts_pkg.sv */
// Shared types and codes of the cooperative task scheduler.
// No dependencies.
`timescale 1ns / 1ps

package cts_pkg;

    localparam int TASK_SLOTS_DEF = 16;
    localparam int MAX_RESULTS    = 16;

    localparam int FUNC_W   = 2;
    localparam int TAG_W    = 16;
    localparam int TIME_W   = 32;
    localparam int INDEX_W  = 8;
    localparam int KIND_W   = 3;
    localparam int SLOT_W   = 4;
    localparam int PEND_W   = 8;

    typedef logic [FUNC_W-1:0] func_t;
    typedef logic [KIND_W-1:0] kind_t;

    localparam func_t FUNC_ADD      = 2'd0;
    localparam func_t FUNC_TICK     = 2'd1;
    localparam func_t FUNC_DISPATCH = 2'd2;
    localparam func_t FUNC_DELETE   = 2'd3;

    localparam kind_t KIND_ADDED    = 3'd0;
    localparam kind_t KIND_FULL     = 3'd1;
    localparam kind_t KIND_DELETED  = 3'd2;
    localparam kind_t KIND_REJECTED = 3'd3;
    localparam kind_t KIND_RUN      = 3'd4;
    localparam kind_t KIND_NONE     = 3'd5;

    localparam logic [PEND_W-1:0] PEND_MAX = '1;

    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic [TIME_W-1:0] delay;
        logic [TIME_W-1:0] period;
        logic [PEND_W-1:0] pending;
    } slot_entry_t;

endpackage

/* rtl/cts_ifs.sv */
// Request and result channels of the cooperative task scheduler.
// Depends on cts_pkg.
`timescale 1ns / 1ps

interface cts_req_if;
    logic                            valid;
    logic                            ready;
    logic [cts_pkg::FUNC_W-1:0]      func;
    logic [cts_pkg::TAG_W-1:0]       task_tag;
    logic [cts_pkg::TIME_W-1:0]      start_delay;
    logic [cts_pkg::TIME_W-1:0]      repeat_period;
    logic [cts_pkg::INDEX_W-1:0]     slot_index;

    modport source (output valid, func, task_tag, start_delay, repeat_period, slot_index,
                    input ready);
    modport sink   (input valid, func, task_tag, start_delay, repeat_period, slot_index,
                    output ready);
endinterface

interface cts_res_if;
    logic                            valid;
    logic                            ready;
    logic [cts_pkg::KIND_W-1:0]      kind;
    logic [cts_pkg::SLOT_W-1:0]      slot;
    logic [cts_pkg::TAG_W-1:0]       run_tag;
    logic                            last;

    modport source (output valid, kind, slot, run_tag, last, input ready);
    modport sink   (input valid, kind, slot, run_tag, last, output ready);
endinterface

/* rtl/cooperative_task_scheduler.sv */
// Cooperative task scheduler: slot table in one memory, valid and ready bits in flops.
// Depends on cts_pkg, cts_ifs and cooperative_task_scheduler_macros.svh.
// A user should know: items are taken one at a time; the block accepts a new request
// whenever it is idle, even while the previous result waits in the output register.
// Add and delete wait in their own state until the output register is free. Tick
// walks the table through the slot memory, passing over free slots and reading, then
// writing back, each valid slot. Dispatch walks the same way over ready slots,
// waiting while the output register is held, and ends at the final ready slot,
// after MAX_RESULTS runs, or with a NONE result when no slot is ready. No clearing
// pass follows reset: slot contents are qualified by valid bits held in flops.
`timescale 1ns / 1ps
`include "cooperative_task_scheduler_macros.svh"

module cooperative_task_scheduler #(
    parameter int TASK_SLOTS = cts_pkg::TASK_SLOTS_DEF
) (
    input  logic  clk,
    input  logic  rst_n,
    cts_req_if.sink   req,
    cts_res_if.source res
);

    localparam int IDX_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
    localparam int CNT_W = $clog2(TASK_SLOTS + 1);
    localparam int RES_W = $clog2(cts_pkg::MAX_RESULTS + 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_ADD  = 3'd1;
    localparam logic [2:0] ST_DEL  = 3'd2;
    localparam logic [2:0] ST_T_RD = 3'd3;
    localparam logic [2:0] ST_T_EV = 3'd4;
    localparam logic [2:0] ST_D_RD = 3'd5;
    localparam logic [2:0] ST_D_EV = 3'd6;

    logic [2:0]                      state_reg, state_next;
    logic [CNT_W-1:0]                idx_reg, idx_next;
    logic [RES_W-1:0]                nres_reg, nres_next;
    logic [TASK_SLOTS-1:0]           valid_reg, valid_next;
    logic [TASK_SLOTS-1:0]           rdy_reg, rdy_next;

    logic [cts_pkg::TAG_W-1:0]       tag_in_reg;
    logic [cts_pkg::TIME_W-1:0]      delay_in_reg;
    logic [cts_pkg::TIME_W-1:0]      period_in_reg;
    logic [cts_pkg::INDEX_W-1:0]     index_in_reg;

    cts_pkg::slot_entry_t            mem [TASK_SLOTS];
    cts_pkg::slot_entry_t            rd_data_reg;
    logic                            mem_re;
    logic                            mem_we;
    logic [IDX_W-1:0]                mem_waddr;
    cts_pkg::slot_entry_t            mem_wdata;

    logic                            out_valid_reg;
    cts_pkg::kind_t                  kind_reg, kind_next;
    logic [cts_pkg::SLOT_W-1:0]      slot_reg, slot_next;
    logic [cts_pkg::TAG_W-1:0]       run_tag_reg, run_tag_next;
    logic                            last_reg, last_next;
    logic                            out_load;
    logic                            out_free;

    logic [IDX_W-1:0]                idx;
    logic [IDX_W-1:0]                free_idx;
    logic                            full;
    logic [TASK_SLOTS-1:0]           ready_mask;
    logic                            more_ready;
    logic [IDX_W+cts_pkg::SLOT_W-1:0] idx_ext;
    logic [IDX_W+cts_pkg::SLOT_W-1:0] free_ext;
    logic                            del_ok;
    logic                            run_last;
    logic [cts_pkg::PEND_W-1:0]      pend_dec;
    cts_pkg::slot_entry_t            tick_entry;

    assign idx        = idx_reg[IDX_W-1:0];
    assign out_free   = !out_valid_reg || res.ready;
    assign ready_mask = valid_reg & rdy_reg;
    assign idx_ext    = {{cts_pkg::SLOT_W{1'b0}}, idx};
    assign free_ext   = {{cts_pkg::SLOT_W{1'b0}}, free_idx};
    assign full       = &valid_reg;
    assign req.ready  = (state_reg == ST_IDLE);

    assign res.valid   = out_valid_reg;
    assign res.kind    = kind_reg;
    assign res.slot    = slot_reg;
    assign res.run_tag = run_tag_reg;
    assign res.last    = last_reg;

    always_comb
    begin
        free_idx = '0;
        for (int i = TASK_SLOTS - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_idx = IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        more_ready = 1'b0;
        for (int i = 0; i < TASK_SLOTS; i++)
        begin
            if (ready_mask[i] && (IDX_W'(i) > idx))
            begin
                more_ready = 1'b1;
            end
        end
    end

    always_comb
    begin
        del_ok = 1'b0;
        if (index_in_reg < cts_pkg::INDEX_W'(TASK_SLOTS))
        begin
            del_ok = valid_reg[index_in_reg[IDX_W-1:0]];
        end
    end

    assign pend_dec = rd_data_reg.pending - 1'b1;
    assign run_last = (nres_reg == RES_W'(cts_pkg::MAX_RESULTS - 1)) || !more_ready;

    always_comb
    begin
        tick_entry = rd_data_reg;
        if (rd_data_reg.delay == '0)
        begin
            if (rd_data_reg.pending != cts_pkg::PEND_MAX)
            begin
                tick_entry.pending = rd_data_reg.pending + 1'b1;
            end
            if (rd_data_reg.period != '0)
            begin
                tick_entry.delay = rd_data_reg.period - 1'b1;
            end
        end
        else
        begin
            tick_entry.delay = rd_data_reg.delay - 1'b1;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        nres_next    = nres_reg;
        valid_next   = valid_reg;
        rdy_next     = rdy_reg;
        mem_re       = 1'b0;
        mem_we       = 1'b0;
        mem_waddr    = idx;
        mem_wdata    = rd_data_reg;
        out_load     = 1'b0;
        kind_next    = cts_pkg::KIND_NONE;
        slot_next    = '0;
        run_tag_next = '0;
        last_next    = 1'b1;

        unique case (state_reg)
            ST_IDLE:
            begin
                idx_next  = '0;
                nres_next = '0;
                if (req.valid)
                begin
                    unique case (req.func)
                        cts_pkg::FUNC_ADD:      state_next = ST_ADD;
                        cts_pkg::FUNC_TICK:     state_next = ST_T_RD;
                        cts_pkg::FUNC_DISPATCH: state_next = ST_D_RD;
                        cts_pkg::FUNC_DELETE:   state_next = ST_DEL;
                        default:                state_next = ST_IDLE;
                    endcase
                end
            end

            ST_ADD:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                    if (full)
                    begin
                        kind_next = cts_pkg::KIND_FULL;
                    end
                    else
                    begin
                        kind_next          = cts_pkg::KIND_ADDED;
                        slot_next          = free_ext[cts_pkg::SLOT_W-1:0];
                        mem_we             = 1'b1;
                        mem_waddr          = free_idx;
                        mem_wdata.tag      = tag_in_reg;
                        mem_wdata.delay    = delay_in_reg;
                        mem_wdata.period   = period_in_reg;
                        mem_wdata.pending  = '0;
                        valid_next[free_idx] = 1'b1;
                        rdy_next[free_idx]   = 1'b0;
                    end
                end
            end

            ST_DEL:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                    if (del_ok)
                    begin
                        kind_next = cts_pkg::KIND_DELETED;
                        slot_next = index_in_reg[cts_pkg::SLOT_W-1:0];
                        valid_next[index_in_reg[IDX_W-1:0]] = 1'b0;
                        rdy_next[index_in_reg[IDX_W-1:0]]   = 1'b0;
                    end
                    else
                    begin
                        kind_next = cts_pkg::KIND_REJECTED;
                    end
                end
            end

            ST_T_RD:
            begin
                if (idx_reg == CNT_W'(TASK_SLOTS))
                begin
                    state_next = ST_IDLE;
                end
                else if (valid_reg[idx])
                begin
                    mem_re     = 1'b1;
                    state_next = ST_T_EV;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            ST_T_EV:
            begin
                mem_we     = 1'b1;
                mem_wdata  = tick_entry;
                if (rd_data_reg.delay == '0)
                begin
                    rdy_next[idx] = 1'b1;
                end
                idx_next   = idx_reg + 1'b1;
                state_next = ST_T_RD;
            end

            ST_D_RD:
            begin
                if (idx_reg == CNT_W'(TASK_SLOTS))
                begin
                    if (out_free)
                    begin
                        out_load   = 1'b1;
                        kind_next  = cts_pkg::KIND_NONE;
                        state_next = ST_IDLE;
                    end
                end
                else if (ready_mask[idx])
                begin
                    mem_re     = 1'b1;
                    state_next = ST_D_EV;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            ST_D_EV:
            begin
                if (out_free)
                begin
                    out_load          = 1'b1;
                    kind_next         = cts_pkg::KIND_RUN;
                    slot_next         = idx_ext[cts_pkg::SLOT_W-1:0];
                    run_tag_next      = rd_data_reg.tag;
                    last_next         = run_last;
                    mem_we            = 1'b1;
                    mem_wdata.pending = pend_dec;
                    if (pend_dec == '0)
                    begin
                        rdy_next[idx] = 1'b0;
                        if ((rd_data_reg.period == '0) && (rd_data_reg.delay == '0))
                        begin
                            valid_next[idx] = 1'b0;
                        end
                    end
                    idx_next   = idx_reg + 1'b1;
                    nres_next  = nres_reg + 1'b1;
                    state_next = run_last ? ST_IDLE : ST_D_RD;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            nres_reg      <= '0;
            valid_reg     <= '0;
            rdy_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            nres_reg  <= nres_next;
            valid_reg <= valid_next;
            rdy_reg   <= rdy_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            tag_in_reg    <= req.task_tag;
            delay_in_reg  <= req.start_delay;
            period_in_reg <= req.repeat_period;
            index_in_reg  <= req.slot_index;
        end
        if (out_load)
        begin
            kind_reg    <= kind_next;
            slot_reg    <= slot_next;
            run_tag_reg <= run_tag_next;
            last_reg    <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[idx];
        end
    end

    `CTS_ASSERT_IMPLY(a_ready_implies_valid, 1'b1, (rdy_reg & ~valid_reg) == '0)
    `CTS_ASSERT_NEXT(a_add_marks_slot, (state_reg == ST_ADD) && out_free && !full, valid_reg[$past(free_idx)])
    `CTS_ASSERT_IMPLY(a_run_from_ready_slot, (state_reg == ST_D_EV), ready_mask[idx])

endmodule
